// ===== hw/rtl/pssd_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the pairwise sum descending sort unit.
// Used by the interfaces, the sort cell and the top level.
package pssd_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int ELEM_W      = 32;
  localparam int SUM_W       = ELEM_W + 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  // Broadcast control from the top level to every cell of the chain.
  typedef struct packed {
    logic ins;    // place the new sum this cycle
    logic shift;  // move every entry one cell towards the head
    sum_t sum;    // new sum being placed
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/pssd_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the pairwise sum descending sort unit.
// Depends on pssd_pkg for the payload types.
interface pssd_in_if;
  import pssd_pkg::*;
  logic  valid;
  logic  ready;
  elem_t elem_a;
  elem_t elem_b;
  logic  final_pair;
  modport source (output valid, output elem_a, output elem_b, output final_pair,
                  input ready);
  modport sink (input valid, input elem_a, input elem_b, input final_pair,
                output ready);
endinterface

interface pssd_out_if;
  import pssd_pkg::*;
  logic valid;
  logic ready;
  sum_t sum_value;
  logic last_out;
  modport source (output valid, output sum_value, output last_out, input ready);
  modport sink (input valid, input sum_value, input last_out, output ready);
endinterface

// ===== hw/rtl/pssd_cell.sv =====
`timescale 1ns / 1ps
// One cell of the descending insertion chain: holds one stored sum.
// Depends on pssd_pkg.
module pssd_cell (
  input  logic                  clk,
  input  pssd_pkg::cell_ctrl_t  ctrl,
  input  logic                  occ,        // cell holds a stored sum
  input  logic                  left_take,  // neighbour towards head takes the new sum
  input  pssd_pkg::sum_t        left_val,
  input  pssd_pkg::sum_t        right_val,
  output logic                  take,
  output pssd_pkg::sum_t        val
);
  import pssd_pkg::*;

  sum_t val_r;
  sum_t val_nxt;

  // New sum goes ahead of a strictly smaller entry, or into an empty cell.
  assign take = !occ || (ctrl.sum > val_r);
  assign val  = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.shift) begin
      val_nxt = right_val;
    end else if (ctrl.ins && take) begin
      val_nxt = left_take ? left_val : ctrl.sum;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ===== hw/rtl/pairwise_sum_sort_descending_unit.sv =====
`timescale 1ns / 1ps
// Top level of the pairwise sum descending sort unit.
// Depends on pssd_pkg, pssd_ifs (channels) and pssd_cell (chain cell).
//
// Usage:
//   in_ch carries one pair (elem_a, elem_b, final_pair) per item. The 33-bit
//   sum of the pair is placed into a chain of MAX_ENTRIES cells kept in
//   descending order; every cell compares in parallel, so a pair is placed in
//   the cycle it is accepted and one pair per cycle is taken while collecting.
//   Once the store is full, the smallest sum drops off the tail.
//   On an item with final_pair set, the sum is placed first; from the next
//   cycle out_ch delivers every stored sum, largest first, straight from the
//   head cell, one per cycle while the receiver is ready, with last_out on the
//   smallest; in_ch.ready stays low for the whole drain, and the stored count
//   clears when the last item leaves.
//   When the receiver stalls, hold the head cell and the whole chain; nothing
//   is lost or repeated.
//   Reset (rst_n low, synchronous) clears the entry count and the drain
//   state; cell contents need no clearing since only occupied cells are read.
module pairwise_sum_sort_descending_unit (
  input  logic clk,
  input  logic rst_n,
  pssd_in_if.sink    in_ch,
  pssd_out_if.source out_ch
);
  import pssd_pkg::*;

  cnt_t count_r, count_nxt;
  cnt_t left_r, left_nxt;    // sums still to deliver
  logic drain_r, drain_nxt;

  logic       in_acc;
  logic       out_acc;
  cell_ctrl_t ctrl;

  sum_t val  [MAX_ENTRIES];
  logic take [MAX_ENTRIES];

  assign in_ch.ready = !drain_r;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_acc     = out_ch.valid && out_ch.ready;

  // Widen both elements before adding so the sum cannot overflow.
  assign ctrl.sum   = sum_t'(in_ch.elem_a) + sum_t'(in_ch.elem_b);
  assign ctrl.ins   = in_acc;
  assign ctrl.shift = out_acc;

  genvar i;
  generate
    for (i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      logic occ;
      logic lt;
      sum_t lv;
      sum_t rv;
      assign occ = cnt_t'(i) < count_r;
      if (i == 0) begin : g_head
        assign lt = 1'b0;
        assign lv = '0;
      end else begin : g_body
        assign lt = take[i-1];
        assign lv = val[i-1];
      end
      if (i == MAX_ENTRIES - 1) begin : g_tail
        assign rv = val[i];
      end else begin : g_mid
        assign rv = val[i+1];
      end
      pssd_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .occ       (occ),
        .left_take (lt),
        .left_val  (lv),
        .right_val (rv),
        .take      (take[i]),
        .val       (val[i])
      );
    end
  endgenerate

  // Deliver from the head cell while draining.
  assign out_ch.valid     = drain_r;
  assign out_ch.sum_value = val[0];
  assign out_ch.last_out  = (left_r == cnt_t'(1));

  always_comb begin
    count_nxt = count_r;
    left_nxt  = left_r;
    drain_nxt = drain_r;
    if (in_acc) begin
      // Advance the count until the store is full; a full store stays full.
      if (count_r < cnt_t'(MAX_ENTRIES)) begin
        count_nxt = count_r + cnt_t'(1);
      end
      if (in_ch.final_pair) begin
        drain_nxt = 1'b1;
        left_nxt  = count_nxt;
      end
    end
    if (out_acc) begin
      left_nxt = left_r - cnt_t'(1);
      if (left_r == cnt_t'(1)) begin
        drain_nxt = 1'b0;
        count_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      left_r  <= '0;
      drain_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      left_r  <= left_nxt;
      drain_r <= drain_nxt;
    end
  end

endmodule

// ===== test/pairwise_sum_sort_descending_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the pairwise sum descending sort unit: streams data sets of
// element pairs and checks every drained sum against a sorted store of its own.
// Depends on pssd_pkg, pssd_ifs and the top level RTL.
module pairwise_sum_sort_descending_unit_tb;
  import pssd_pkg::*;

  // One pending input item plus the idle cycles the sender takes after it.
  typedef struct {
    elem_t       a;
    elem_t       b;
    logic        fin;
    int unsigned gap;
  } pair_item_t;

  // One sum as it should leave the drain.
  typedef struct {
    sum_t sum;
    logic last;
  } drained_sum_t;

  // How the elements of a random data set are picked.
  typedef enum int {
    VAL_RANDOM,   // full 32-bit random
    VAL_TIES,     // tiny range, so equal sums are common
    VAL_EXTREME,  // mostly the field limits, zero and minus one
    VAL_SHORT_B   // second array runs out half way: elem_b is zero after that
  } value_mode_t;

  localparam elem_t ELEM_MAX = elem_t'(32'h7FFF_FFFF);
  localparam elem_t ELEM_MIN = elem_t'(32'h8000_0000);
  localparam int RANDOM_ITEMS = 480;
  localparam int MAX_STALL    = 5;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_TAIL   = 20;

  logic clk;
  logic rst_n;

  pssd_in_if  in_if ();
  pssd_out_if out_if ();

  pairwise_sum_sort_descending_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: own copy of the descending store and its count
  // ---------------------------------------------------------------------------
  sum_t         ranked_sums [MAX_ENTRIES];
  int           ranked_count;
  drained_sum_t expected_sums [$];

  // Place the sum of one accepted pair; on the final pair, queue the whole
  // store for the drain, largest first, and empty it.
  task automatic rank_pair(elem_t a, elem_t b, logic fin);
    sum_t         s;
    int           slot;
    drained_sum_t ds;
    // widen both elements by their sign bit so the add cannot overflow
    s = sum_t'({a[ELEM_W-1], a}) + sum_t'({b[ELEM_W-1], b});
    if (ranked_count < MAX_ENTRIES) begin
      slot = ranked_count;
      ranked_count++;
    end else if (s > ranked_sums[MAX_ENTRIES-1]) begin
      // store full: the tail entry drops off
      slot = MAX_ENTRIES - 1;
    end else begin
      // store full and not larger than the smallest: drop the new sum
      slot = MAX_ENTRIES;
    end
    if (slot < MAX_ENTRIES) begin
      // move ahead of strictly smaller entries only, so ties keep their order
      while (slot > 0 && s > ranked_sums[slot-1]) begin
        ranked_sums[slot] = ranked_sums[slot-1];
        slot--;
      end
      ranked_sums[slot] = s;
    end
    if (fin) begin
      for (int k = 0; k < ranked_count; k++) begin
        ds.sum  = ranked_sums[k];
        ds.last = (k + 1 == ranked_count);
        expected_sums.push_back(ds);
      end
      ranked_count = 0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus store, filled at time zero
  // ---------------------------------------------------------------------------
  pair_item_t pending_pairs [$];
  int         pairs_queued;
  int         pairs_sent;

  task automatic queue_pair(elem_t a, elem_t b, logic fin, int unsigned gap);
    pair_item_t p;
    p.a   = a;
    p.b   = b;
    p.fin = fin;
    p.gap = gap;
    pending_pairs.push_back(p);
    pairs_queued++;
  endtask

  function automatic elem_t pick_elem(value_mode_t mode);
    case (mode)
      VAL_TIES:    return elem_t'(int'($urandom_range(0, 6)) - 3);
      VAL_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       return ELEM_MAX;
          1:       return ELEM_MIN;
          2:       return '0;
          3:       return '1;
          default: return elem_t'($urandom);
        endcase
      end
      default:     return elem_t'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present pending items, predict each one as it is accepted
  // ---------------------------------------------------------------------------
  pair_item_t  held_pair;
  int unsigned send_gap;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      send_gap    <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        rank_pair(held_pair.a, held_pair.b, held_pair.fin);
        pairs_sent++;
      end
      // advance only when nothing is on offer or the offer was just taken
      if (!in_if.valid || in_if.ready) begin
        if (send_gap > 0) begin
          send_gap    <= send_gap - 1;
          in_if.valid <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
          held_pair        = pending_pairs.pop_front();
          in_if.elem_a     <= held_pair.a;
          in_if.elem_b     <= held_pair.b;
          in_if.final_pair <= held_pair.fin;
          in_if.valid      <= 1'b1;
          send_gap         <= held_pair.gap;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: stall at random, compare each drained item with the oldest sum
  // ---------------------------------------------------------------------------
  int           mismatch_count;
  int unsigned  recv_stall;
  int unsigned  stall_draw;
  bit           recv_burst;
  drained_sum_t oldest_sum;

  task automatic log_mismatch(string why, sum_t want_sum, logic want_last);
    if (mismatch_count < MAX_REPORTS)
      $display("%0t: %s: expected sum %0d last %b, got sum %0d last %b", $realtime, why,
               want_sum, want_last, out_if.sum_value, out_if.last_out);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      recv_stall   <= $urandom_range(0, MAX_STALL);
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_sums.size() == 0) begin
          log_mismatch("item with nothing expected", '0, 1'b0);
        end else begin
          oldest_sum = expected_sums.pop_front();
          if (out_if.sum_value !== oldest_sum.sum || out_if.last_out !== oldest_sum.last)
            log_mismatch("wrong item", oldest_sum.sum, oldest_sum.last);
        end
        // flip between stalling and full-rate stretches now and then
        if ($urandom_range(0, 29) == 0)
          recv_burst = !recv_burst;
        stall_draw   = recv_burst ? 0 : $urandom_range(0, MAX_STALL);
        recv_stall   <= stall_draw;
        out_if.ready <= (stall_draw == 0);
      end else if (recv_stall > 0) begin
        // count the stall down only while an item is waiting, so it can also
        // fall on the first item of the next drain
        if (out_if.valid) begin
          recv_stall   <= recv_stall - 1;
          out_if.ready <= (recv_stall == 1);
        end
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int          set_len;
    int          rand_count;
    bit          burst;
    value_mode_t mode;
    elem_t       ea;
    elem_t       eb;

    // hold every block input at a known value from time zero
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.elem_a     = '0;
    in_if.elem_b     = '0;
    in_if.final_pair = 1'b0;
    out_if.ready     = 1'b0;
    ranked_count     = 0;
    pairs_queued     = 0;
    pairs_sent       = 0;
    mismatch_count   = 0;
    recv_burst       = 1'b0;
    foreach (ranked_sums[i]) ranked_sums[i] = '0;

    // Directed part.
    // Data sets of one pair at the top and bottom of the sum range.
    queue_pair(ELEM_MAX, ELEM_MAX, 1'b1, $urandom_range(0, MAX_STALL));
    queue_pair(ELEM_MIN, ELEM_MIN, 1'b1, $urandom_range(0, MAX_STALL));
    // Mixed signs, zero, a shorter second array and equal sums.
    queue_pair(ELEM_MAX, ELEM_MIN, 1'b0, $urandom_range(0, MAX_STALL));
    queue_pair('0, '0, 1'b0, $urandom_range(0, MAX_STALL));
    queue_pair(ELEM_MIN, '0, 1'b0, $urandom_range(0, MAX_STALL));
    queue_pair('0, ELEM_MAX, 1'b0, $urandom_range(0, MAX_STALL));
    queue_pair(elem_t'(1), elem_t'(2), 1'b0, $urandom_range(0, MAX_STALL));
    queue_pair(elem_t'(2), elem_t'(1), 1'b0, $urandom_range(0, MAX_STALL));
    queue_pair(elem_t'(3), '0, 1'b0, $urandom_range(0, MAX_STALL));
    queue_pair(ELEM_MAX, elem_t'(1), 1'b0, $urandom_range(0, MAX_STALL));
    queue_pair('1, '0, 1'b1, $urandom_range(0, MAX_STALL));
    // Two data sets of descending sums, each new one going to the tail. Both at
    // full rate.
    for (int i = 1; i <= 5; i++) queue_pair(elem_t'(i), elem_t'(-2 * i), i == 5, 0);
    for (int i = 5; i >= 1; i--) queue_pair(elem_t'(i), elem_t'(i), i == 1, 0);

    // Random part: mostly short data sets, now and then one that overfills
    // the store so the smallest sums drop off the tail.
    rand_count = 0;
    while (rand_count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0)
        set_len = $urandom_range(MAX_ENTRIES + 1, MAX_ENTRIES + 24);
      else
        set_len = $urandom_range(1, 16);
      mode  = value_mode_t'($urandom_range(VAL_RANDOM, VAL_SHORT_B));
      burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < set_len; i++) begin
        ea = pick_elem(mode);
        eb = (mode == VAL_SHORT_B && i >= set_len / 2) ? elem_t'(0) : pick_elem(mode);
        queue_pair(ea, eb, i == set_len - 1, burst ? 0 : $urandom_range(0, MAX_STALL));
      end
      rand_count += set_len;
    end

    // synchronous reset, released at a rising edge
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // wait for every item to be taken and every sum to be drained
    wait (pairs_sent == pairs_queued);
    wait (expected_sums.size() == 0);
    repeat (DRAIN_TAIL) @(posedge clk);

    if (mismatch_count == 0 && expected_sums.size() == 0) begin
      $display("pairwise_sum_sort_descending_unit: match");
    end else begin
      $display("pairwise_sum_sort_descending_unit: mismatch");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("pairwise_sum_sort_descending_unit: mismatch");
    $finish;
  end

endmodule
